// ===== hw/rtl/bfce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfce_pkg
// Shared types, widths and the reciprocal table of the clamped box filter.
// ----------------------------------------------------------------------------
package bfce_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RAD_W       = 5;
    localparam int RAD_MAX     = (1 << RAD_W) - 1;
    localparam int POS_W       = 16;
    localparam int SUM_W       = 22;              // 63 full-scale samples
    localparam int NE_W        = RAD_W + 1;
    localparam int AGE_W       = RAD_W + 2;
    localparam int EXT_W       = AGE_W + 1;
    localparam int PA_W        = RAD_W + SAMPLE_W;
    localparam int PB_W        = NE_W + SAMPLE_W;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                row_end;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic                final_res;
    } t_out;

    // One window to evaluate: prefix at the newest sample, replication counts
    // for the right (newest) and left (row start) clamps.
    typedef struct packed {
        logic [SUM_W-1:0]    ptop;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] edge_val;
        logic [RAD_W-1:0]    nr;
        logic [NE_W-1:0]     ne;
        logic                zero_q;
        logic [RAD_W-1:0]    radius;
        logic                final_res;
    } t_job;

    // ceil(2^28 / (2r+1)); exact floor division for any dividend below 2^22
    function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
        logic [RECIP_W-1:0] m;
        unique case (r)
            5'd0:  m = 29'd268435456;
            5'd1:  m = 29'd89478486;
            5'd2:  m = 29'd53687092;
            5'd3:  m = 29'd38347923;
            5'd4:  m = 29'd29826162;
            5'd5:  m = 29'd24403224;
            5'd6:  m = 29'd20648882;
            5'd7:  m = 29'd17895698;
            5'd8:  m = 29'd15790321;
            5'd9:  m = 29'd14128182;
            5'd10: m = 29'd12782641;
            5'd11: m = 29'd11671107;
            5'd12: m = 29'd10737419;
            5'd13: m = 29'd9942054;
            5'd14: m = 29'd9256396;
            5'd15: m = 29'd8659209;
            5'd16: m = 29'd8134408;
            5'd17: m = 29'd7669585;
            5'd18: m = 29'd7255013;
            5'd19: m = 29'd6882961;
            5'd20: m = 29'd6547207;
            5'd21: m = 29'd6242686;
            5'd22: m = 29'd5965233;
            5'd23: m = 29'd5711393;
            5'd24: m = 29'd5478275;
            5'd25: m = 29'd5263441;
            5'd26: m = 29'd5064820;
            5'd27: m = 29'd4880645;
            5'd28: m = 29'd4709394;
            5'd29: m = 29'd4549754;
            5'd30: m = 29'd4400582;
            5'd31: m = 29'd4260881;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/bfce_mean_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfce_mean_pipe
// Window sum from prefix difference plus clamp terms, rounded mean by
// reciprocal multiply, output register. Bubble-collapsing valid chain.
// ----------------------------------------------------------------------------
module bfce_mean_pipe
    import bfce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_issue,
    input  t_job             i_job,
    input  logic [SUM_W-1:0] i_rd_prefix,   // memory data, aligned with J1
    output logic             o_ready,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data
);

    logic                r_j1_v;
    t_job                r_j1;
    logic                r_j2_v;
    logic [SUM_W-1:0]    r_j2_diff;
    logic [PA_W-1:0]     r_j2_pa;
    logic [PB_W-1:0]     r_j2_pb;
    logic [RAD_W-1:0]    r_j2_r;
    logic                r_j2_fin;
    logic                r_j3_v;
    logic [SUM_W-1:0]    r_j3_x;
    logic [RECIP_W-1:0]  r_j3_m;
    logic                r_j3_fin;
    logic                r_out_valid;
    t_out                r_out;

    logic                out_ready;
    logic                j3_ready;
    logic                j2_ready;
    logic [SUM_W-1:0]    n_diff;
    logic [PA_W-1:0]     n_pa;
    logic [PB_W-1:0]     n_pb;
    logic [SUM_W-1:0]    n_x;
    logic [PROD_W-1:0]   prod;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign j3_ready  = !r_j3_v || out_ready;
    assign j2_ready  = !r_j2_v || j3_ready;
    assign o_ready   = !r_j1_v || j2_ready;

    // J1: prefix difference and clamp replication products
    assign n_diff = r_j1.ptop - (r_j1.zero_q ? '0 : i_rd_prefix);
    assign n_pa   = PA_W'(r_j1.nr) * PA_W'(r_j1.sample);
    assign n_pb   = PB_W'(r_j1.ne) * PB_W'(r_j1.edge_val);

    // J2: full window sum plus half divisor for round half-up
    assign n_x = SUM_W'(r_j2_diff + SUM_W'(r_j2_pa) + SUM_W'(r_j2_pb) + SUM_W'(r_j2_r));

    // J3: multiply by reciprocal
    assign prod = PROD_W'(r_j3_x) * PROD_W'(r_j3_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j1_v      <= 1'b0;
            r_j2_v      <= 1'b0;
            r_j3_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready)   r_j1_v      <= i_issue;
            if (j2_ready)  r_j2_v      <= r_j1_v;
            if (j3_ready)  r_j3_v      <= r_j2_v;
            if (out_ready) r_out_valid <= r_j3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_j1 <= i_job;
        end
        if (j2_ready) begin
            r_j2_diff <= n_diff;
            r_j2_pa   <= n_pa;
            r_j2_pb   <= n_pb;
            r_j2_r    <= r_j1.radius;
            r_j2_fin  <= r_j1.final_res;
        end
        if (j3_ready) begin
            r_j3_x   <= n_x;
            r_j3_m   <= recip(r_j2_r);
            r_j3_fin <= r_j2_fin;
        end
        if (out_ready) begin
            r_out.filtered  <= prod[RECIP_SHIFT +: SAMPLE_W];
            r_out.final_res <= r_j3_fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_issue_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_issue |-> o_ready)
        else $error("job issued while J1 cannot take it");

    a_j1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j1_v && !j2_ready |=> r_j1_v && $stable(r_j1))
        else $error("J1 job lost under back pressure");

    a_j3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j3_v && !out_ready |=> r_j3_v && $stable(r_j3_x))
        else $error("J3 operand lost under back pressure");
`endif

endmodule

// ===== hw/rtl/box_filter_clamped_edges_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_clamped_edges_unit
// Streaming 1-D box filter over a row, edges clamped, rounded mean.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one sample
//   per transfer; row_end marks the last sample of a row. Output channel
//   (o_out_valid / i_out_stall / o_out_data) carries filtered results, and
//   final_res marks the last result of the row.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_radius) sets the window
//   half width; ready is always high. Write it between transfers only.
//   Throughput: one sample per cycle unless a flush or output stall holds the
//   input. Output x leaves once sample x+r is in. A row_end sample with
//   radius r and row length N raises o_in_stall for a flush of min(N, r)
//   pending windows, issued through the single job port into the pipeline.
//   Each job passes J1, J2, J3 and the output register before o_out_valid rises.
//   Reset (synchronous, active low) empties the pipeline, zeroes the radius
//   and starts a new row. No memory clearing pass is needed.
//   When the receiver stalls, the output register holds; the pipeline keeps
//   filling its empty stages and keeps taking samples until it is full.
// ----------------------------------------------------------------------------
module box_filter_clamped_edges_unit
    import bfce_pkg::*;
#(
    parameter int MAX_RADIUS = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [RAD_W-1:0] i_cfg_radius
);

    // Only radii the 5-bit register can express matter.
    localparam int R_EFF = (MAX_RADIUS < RAD_MAX) ? MAX_RADIUS : RAD_MAX;
    localparam int DEPTH = 2 * R_EFF + 2;
    localparam int AW    = $clog2(DEPTH);

    // Ring of row prefix sums (mod 2^SUM_W); window sums are differences.
    logic [SUM_W-1:0]    r_hist [DEPTH];
    logic [SUM_W-1:0]    r_rd_prefix;

    // Row state
    logic [RAD_W-1:0]    r_radius;
    logic [POS_W-1:0]    r_pos;
    logic [SUM_W-1:0]    r_prefix;
    logic [SAMPLE_W-1:0] r_edge;
    logic [AW-1:0]       r_head;

    // Flush context captured from the row_end sample
    logic                r_fl_active;
    logic [RAD_W-1:0]    r_fl_j;
    logic [RAD_W-1:0]    r_fl_r;
    logic [POS_W-1:0]    r_fl_p;
    logic [SUM_W-1:0]    r_fl_ptop;
    logic [SAMPLE_W-1:0] r_fl_s;
    logic [SAMPLE_W-1:0] r_fl_edge;
    logic [AW-1:0]       r_fl_newest;

    logic [RAD_W-1:0]    n_radius;
    logic [POS_W-1:0]    n_pos;
    logic [SUM_W-1:0]    n_prefix;
    logic [SAMPLE_W-1:0] n_edge;
    logic [AW-1:0]       n_head;
    logic                n_fl_active;
    logic [RAD_W-1:0]    n_fl_j;

    logic                j1_ready;
    logic                in_acc;
    logic                acc_job;
    logic                fl_issue;
    logic                issue;
    logic [RAD_W-1:0]    cur_radius;
    logic [SUM_W-1:0]    p_new;
    logic [SAMPLE_W-1:0] edge_new;

    logic [RAD_W-1:0]    sel_b;
    logic [RAD_W-1:0]    sel_r;
    logic [POS_W-1:0]    sel_p;
    logic [AW-1:0]       sel_newest;
    logic [NE_W-1:0]     br;
    logic [AGE_W-1:0]    age;
    logic [EXT_W-1:0]    ext_new;
    logic [EXT_W-1:0]    ext_age;
    logic [AW-1:0]       rd_addr;
    t_job                job;

    assign o_cfg_ready = 1'b1;

    assign cur_radius = (r_radius > RAD_W'(R_EFF)) ? RAD_W'(R_EFF) : r_radius;

    // Input is held during a flush and whenever J1 cannot take a job.
    assign o_in_stall = r_fl_active || !j1_ready;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign acc_job    = in_acc && (r_pos >= POS_W'(cur_radius));
    assign fl_issue   = r_fl_active && j1_ready;
    assign issue      = acc_job || fl_issue;

    // A new row restarts the prefix and latches its edge sample.
    assign p_new    = (r_pos == '0) ? SUM_W'(i_in_data.sample)
                                    : r_prefix + SUM_W'(i_in_data.sample);
    assign edge_new = (r_pos == '0) ? i_in_data.sample : r_edge;

    // Job for window centered 'b' samples before the newest one.
    // Ages below zero replicate the newest sample (nr copies), ages past the
    // row start replicate the edge sample (ne copies); the rest is
    // prefix(newest) - prefix(age b+r+1), or the whole prefix if that age
    // lies before the row.
    always_comb begin
        if (r_fl_active) begin
            sel_b          = r_fl_j;
            sel_r          = r_fl_r;
            sel_p          = r_fl_p;
            sel_newest     = r_fl_newest;
            job.ptop       = r_fl_ptop;
            job.sample     = r_fl_s;
            job.edge_val   = r_fl_edge;
            job.final_res  = (r_fl_j == '0);
        end else begin
            sel_b          = cur_radius;
            sel_r          = cur_radius;
            sel_p          = r_pos;
            sel_newest     = r_head;
            job.ptop       = p_new;
            job.sample     = i_in_data.sample;
            job.edge_val   = edge_new;
            job.final_res  = i_in_data.row_end && (cur_radius == '0);
        end
        br         = NE_W'(sel_b) + NE_W'(sel_r);
        job.radius = sel_r;
        job.nr     = sel_r - sel_b;
        job.zero_q = (POS_W'(br) >= sel_p);
        job.ne     = job.zero_q ? NE_W'(POS_W'(br) - sel_p) : '0;
        age        = AGE_W'(br) + AGE_W'(1);
        ext_new    = EXT_W'(sel_newest);
        ext_age    = EXT_W'(age);
        rd_addr    = (ext_new >= ext_age) ? AW'(ext_new - ext_age)
                                          : AW'(ext_new + EXT_W'(DEPTH) - ext_age);
    end

    // Row and flush state
    always_comb begin
        n_radius    = i_cfg_valid ? i_cfg_radius : r_radius;
        n_pos       = r_pos;
        n_prefix    = r_prefix;
        n_edge      = r_edge;
        n_head      = r_head;
        n_fl_active = r_fl_active;
        n_fl_j      = r_fl_j;
        if (in_acc) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
            if (i_in_data.row_end) begin
                n_pos       = '0;
                n_prefix    = '0;
                n_edge      = '0;
                n_fl_active = (cur_radius != '0);
                n_fl_j      = (r_pos < POS_W'(cur_radius)) ? RAD_W'(r_pos)
                                                           : cur_radius - RAD_W'(1);
            end else begin
                n_pos    = (r_pos == '1) ? r_pos : r_pos + POS_W'(1);
                n_prefix = p_new;
                n_edge   = edge_new;
            end
        end else if (fl_issue) begin
            if (r_fl_j == '0) begin
                n_fl_active = 1'b0;
            end else begin
                n_fl_j = r_fl_j - RAD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= '0;
            r_pos       <= '0;
            r_prefix    <= '0;
            r_edge      <= '0;
            r_head      <= '0;
            r_fl_active <= 1'b0;
            r_fl_j      <= '0;
        end else begin
            r_radius    <= n_radius;
            r_pos       <= n_pos;
            r_prefix    <= n_prefix;
            r_edge      <= n_edge;
            r_head      <= n_head;
            r_fl_active <= n_fl_active;
            r_fl_j      <= n_fl_j;
        end
    end

    // Flush context payload
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.row_end) begin
            r_fl_r      <= cur_radius;
            r_fl_p      <= r_pos;
            r_fl_ptop   <= p_new;
            r_fl_s      <= i_in_data.sample;
            r_fl_edge   <= edge_new;
            r_fl_newest <= r_head;
        end
    end

    // Prefix memory: write at the newest slot, read an older slot. The read
    // age is at least one, so the two never collide and no bypass is needed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hist[r_head] <= p_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_prefix <= r_hist[rd_addr];
        end
    end

    bfce_mean_pipe u_mean (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_job       (job),
        .i_rd_prefix (r_rd_prefix),
        .o_ready     (j1_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_job && !job.zero_q |-> rd_addr != r_head)
        else $error("prefix read hits the slot being written");

    a_flush_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.row_end && cur_radius != '0 |=> r_fl_active)
        else $error("row end with nonzero radius did not start a flush");

    a_flush_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fl_issue && r_fl_j == '0 |=> !r_fl_active)
        else $error("flush did not end after its last window");

    a_flush_new_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fl_active |-> r_pos == '0)
        else $error("row position not cleared during flush");
`endif

endmodule

// ===== tb/box_filter_clamped_edges_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_clamped_edges_unit_tb
// Self-checking bench for the clamped-edge streaming box filter.
// Rows of samples go in at several radius settings. An in-bench row model
// predicts every filtered output, and each output transfer is checked in
// order against it. Both channels idle at random, in rotating phases.
// ----------------------------------------------------------------------------
module box_filter_clamped_edges_unit_tb
    import bfce_pkg::*;
;

    localparam int HIST_DEPTH     = 64;         // 2*31+2 sample ring
    localparam int POS_LIMIT      = 65535;      // row position saturates here
    localparam int SETTLE_CYCLES  = 8;          // lets the mean pipeline empty after the last predicted output
    localparam int STUCK_LIMIT    = 5000;       // cycles without any transfer
    localparam int RANDOM_ITEMS   = 160;
    localparam int REPORT_LIMIT   = 10;

    // Sender/receiver idling phases
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // ------------------------------------------------------------------------
    // Row model and ordered store of expected filter outputs
    // ------------------------------------------------------------------------
    class filter_scoreboard;
        t_out                 expected_q[$];
        logic [SAMPLE_W-1:0]  ring[HIST_DEPTH];
        int unsigned          ring_head;
        int unsigned          row_pos;
        logic [SAMPLE_W-1:0]  first_sample;
        int unsigned          radius;
        int                   mismatches;

        function new();
            foreach (ring[i]) ring[i] = '0;
            ring_head    = 0;
            row_pos      = 0;
            first_sample = '0;
            radius       = 0;
            mismatches   = 0;
        endfunction

        function void set_radius(logic [RAD_W-1:0] r);
            radius = r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Sample `age` steps behind the newest one; left edge clamps to the
        // row's first sample.
        function logic [SAMPLE_W-1:0] tap(int unsigned newest, int unsigned age,
                                          int unsigned p);
            if (age > p)
                return first_sample;
            return ring[(newest + HIST_DEPTH - (age % HIST_DEPTH)) % HIST_DEPTH];
        endfunction

        // Rounded-half-up mean of the window centered `back` samples ago.
        // Right edge clamps by folding negative ages onto the newest sample.
        function logic [SAMPLE_W-1:0] box_mean(int unsigned newest, int back,
                                               int r, int unsigned p);
            longint unsigned acc;
            int unsigned     age;
            acc = 0;
            for (int a = back - r; a <= back + r; a++) begin
                age = (a < 0) ? 0 : a;
                acc += tap(newest, age, p);
            end
            return SAMPLE_W'((acc + r) / (2 * r + 1));
        endfunction

        function void note_sample(t_in d);
            int          r;
            int unsigned p;
            int unsigned newest;
            int          j;
            t_out        res;
            r      = radius;
            p      = row_pos;
            newest = ring_head % HIST_DEPTH;

            ring[newest] = d.sample;
            ring_head    = (newest + 1) % HIST_DEPTH;
            if (p == 0)
                first_sample = d.sample;

            if (p >= r) begin
                res.filtered  = box_mean(newest, r, r, p);
                res.final_res = d.row_end && (r == 0);
                expected_q.push_back(res);
            end

            if (d.row_end) begin
                // flush the windows still waiting for right-hand samples
                j = (p < r) ? p : r - 1;
                if (r == 0)
                    j = -1;
                for (; j >= 0; j--) begin
                    res.filtered  = box_mean(newest, j, r, p);
                    res.final_res = (j == 0);
                    expected_q.push_back(res);
                end
                row_pos      = 0;
                first_sample = '0;
            end else if (row_pos < POS_LIMIT) begin
                row_pos++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected output: filtered=%h final=%b",
                             got.filtered, got.final_res);
                return;
            end
            want = expected_q.pop_front();
            if (got.filtered !== want.filtered || got.final_res !== want.final_res) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("output mismatch: filtered exp %h got %h, final exp %b got %b",
                             want.filtered, got.filtered, want.final_res, got.final_res);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals
    // ------------------------------------------------------------------------
    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_stall;
    t_in              i_in_data    = '0;
    logic             o_out_valid;
    logic             i_out_stall  = 1'b0;
    t_out             o_out_data;
    logic             i_cfg_valid  = 1'b0;
    logic             o_cfg_ready;
    logic [RAD_W-1:0] i_cfg_radius = '0;

    filter_scoreboard sb = new();

    int send_idle_pct  = 0;     // chance per cycle the sender holds off
    int recv_stall_pct = 0;     // chance per cycle the receiver stalls
    int stuck_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    box_filter_clamped_edges_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_radius (i_cfg_radius)
    );

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Output monitor: pre-edge values are sampled here, so no race with the DUT
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
    end

    // Watchdog on any transfer across the three channels
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic set_idle_mode(input t_idle_mode m);
        case (m)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 46;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 46;
            end
            default: begin
                send_idle_pct  = 28;
                recv_stall_pct = 28;
            end
        endcase
    endtask

    // One sample transfer; valid stays up afterwards so back-to-back
    // samples do not toggle it within a step.
    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic last);
        t_in d;
        d.sample  = s;
        d.row_end = last;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(d);
    endtask

    // Hold off the sender until every predicted output is out, then let the
    // pipeline settle; samples that produce no output may still be in flight.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [RAD_W-1:0] r);
        drain();
        i_cfg_valid  <= 1'b1;
        i_cfg_radius <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        sb.set_radius(r);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAD_W-1:0] pick_radius();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return RAD_W'($urandom_range(1, 8));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int rows;
        int len;
        int r;
        int cut;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset radius is zero: samples pass straight through, every output
        // of a row-end sample is the final one.
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h1234, 1'b1);

        // Widest window on rows shorter than the radius, clamped both sides
        write_radius(5'd31);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h8000, 1'b1);        // one-sample row

        // Radius 1 with full-scale and zero samples
        write_radius(5'd1);
        set_idle_mode(IDLE_BOTH);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b1);

        // Radius changed in the middle of a row
        write_radius(5'd2);
        push_sample(16'hAAAA, 1'b0);
        push_sample(16'h5555, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        write_radius(5'd5);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0001, 1'b1);

        // Random rows; idle phase rotates per row, radius changes every
        // other row and now and then mid-row.
        sent = 0;
        rows = 0;
        while (sent < RANDOM_ITEMS) begin
            set_idle_mode(t_idle_mode'(rows % 4));
            if (rows % 2 == 0)
                write_radius(pick_radius());
            r = sb.radius;
            case ($urandom_range(3))
                0:       len = $urandom_range(1, 3);
                1:       len = $urandom_range(1, r + 1);
                default: len = $urandom_range(r + 1, 2 * r + 20);
            endcase
            cut = ($urandom_range(7) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
            for (int i = 0; i < len; i++) begin
                if (i == cut)
                    write_radius(pick_radius());
                push_sample(pick_sample(), i == len - 1);
                sent++;
            end
            rows++;
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== box_filter_clamped_edges_unit.f =====
hw/rtl/bfce_pkg.sv
hw/rtl/bfce_mean_pipe.sv
hw/rtl/box_filter_clamped_edges_unit.sv
tb/box_filter_clamped_edges_unit_tb.sv
